[rtl/jbse_pkg.sv]
// jbse_pkg: constants, types and helper functions of the jpeg block symbol encoder
// used by every file of the block; depends on nothing

package jbse_pkg;

	localparam int COMPONENTS  = 4;
	localparam int EOB_RUN_MAX = 32767;
	localparam int COEF_BITS   = 23;

	localparam int COMP_BITS   = 2;
	localparam int POS_BITS    = 6;
	localparam int SHIFT_BITS  = 4;
	localparam int AMP_BITS    = COEF_BITS + 1;
	localparam int CAT_BITS    = $clog2(AMP_BITS + 1);
	localparam int EOBR_BITS   = 15;
	localparam int ZRUN_BITS   = 6;
	localparam int CFG_BITS    = 6;
	localparam int IDX_BITS    = 3;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

	localparam logic [7:0] SYM_ZRL = 8'hf0;
	localparam logic [7:0] SYM_ESC = 8'h10;
	localparam logic [7:0] SYM_EOB = 8'h00;

	localparam logic [2:0] RUN_LEN      = 3'd4;
	localparam int         ZRL_SPAN     = 15;
	localparam int         CAT_LARGE    = 16;
	localparam int         CAT_LIMIT_LR = 22;
	localparam logic [COEF_BITS-1:0] ESC_MAG = COEF_BITS'(32'h8000);

	typedef enum logic [IDX_BITS-1:0] {
		REG_SCAN_START,
		REG_SCAN_STOP,
		REG_POINT_SHIFT,
		REG_DIFFERENTIAL,
		REG_RESIDUAL,
		REG_LARGE_RANGE,
		REG_PROGRESSIVE
	} reg_index_t;

	typedef struct packed {
		logic [POS_BITS-1:0]   scan_start;
		logic [POS_BITS-1:0]   scan_stop;
		logic [SHIFT_BITS-1:0] point_shift;
		logic                  differential;
		logic                  residual;
		logic                  large_range;
		logic                  progressive;
	} cfg_t;

	typedef struct packed {
		logic                 table_select;
		logic [COMP_BITS-1:0] comp_out;
		logic [7:0]           symbol;
		logic [2:0]           run_bits_len;
		logic [3:0]           run_bits;
		logic [CAT_BITS-1:0]  amp_len;
		logic [AMP_BITS-1:0]  amp_bits;
		logic                 status;
		logic                 last;
	} result_t;

	typedef struct packed {
		logic [COMP_BITS-1:0]                  comp;
		logic [COMPONENTS-1:0]                 eob_mask;
		logic [COMPONENTS-1:0][EOBR_BITS-1:0]  eob_runs;
		logic [1:0]                            zrl_cnt;
		logic                                  sym_valid;
		result_t                               sym;
	} cmd_t;

	function automatic logic [CAT_BITS-1:0] bit_length(input logic [AMP_BITS-1:0] v);
		logic [CAT_BITS-1:0] n;
		n = '0;
		for (int i = 0; i < AMP_BITS; i++) begin
			if (v[i]) begin
				n = CAT_BITS'(i + 1);
			end
		end
		return n;
	endfunction

	function automatic logic [AMP_BITS-1:0] low_mask(input logic [CAT_BITS-1:0] n);
		return ~({AMP_BITS{1'b1}} << n);
	endfunction

endpackage

[rtl/jpeg_block_symbol_encoder.sv]
// jpeg_block_symbol_encoder: top level, configuration registers and the
// front / queue / back chain; depends on jbse_pkg, jbse_front, jbse_queue, jbse_back
//
// channel   direction  handshake              payload
// in        input      in_valid / in_stall    kind, component, scan_pos, coefficient
// out       output     out_valid / out_stall  table_select .. amp_bits, status, last
// cfg       input      cfg_we                 cfg_index, cfg_data
//
// one item per cycle into a two-stage front while in_stall is low; the back sends
// the result beats of an item one at a time, up to 5 beats for one item
// a four-command queue absorbs result bursts; in_stall rises only when it is full
// reset clears predictors, eob runs, zero run and the registers but scan_stop, which
// resets to 63; no clearing pass; out_stall holds the output register and, through the queue, the front

module jpeg_block_symbol_encoder (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [jbse_pkg::IDX_BITS-1:0]          cfg_index,
	input  logic [jbse_pkg::CFG_BITS-1:0]          cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic                                   kind,
	input  logic [jbse_pkg::COMP_BITS-1:0]         component,
	input  logic [jbse_pkg::POS_BITS-1:0]          scan_pos,
	input  logic signed [jbse_pkg::COEF_BITS-1:0]  coefficient,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic                                   table_select,
	output logic [jbse_pkg::COMP_BITS-1:0]         comp_out,
	output logic [7:0]                             symbol,
	output logic [2:0]                             run_bits_len,
	output logic [3:0]                             run_bits,
	output logic [jbse_pkg::CAT_BITS-1:0]          amp_len,
	output logic [jbse_pkg::AMP_BITS-1:0]          amp_bits,
	output logic                                   status,
	output logic                                   last
);

	jbse_pkg::cfg_t    cfg_q;
	jbse_pkg::cmd_t    cmd, head;
	logic              cmd_valid, q_full, q_empty, pop;
	jbse_pkg::result_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scan_start   <= '0;
			cfg_q.scan_stop    <= '1;
			cfg_q.point_shift  <= '0;
			cfg_q.differential <= 1'b0;
			cfg_q.residual     <= 1'b0;
			cfg_q.large_range  <= 1'b0;
			cfg_q.progressive  <= 1'b0;
		end else if (cfg_we) begin
			unique case (jbse_pkg::reg_index_t'(cfg_index))
				jbse_pkg::REG_SCAN_START:   cfg_q.scan_start   <= cfg_data;
				jbse_pkg::REG_SCAN_STOP:    cfg_q.scan_stop    <= cfg_data;
				jbse_pkg::REG_POINT_SHIFT:  cfg_q.point_shift  <= cfg_data[jbse_pkg::SHIFT_BITS-1:0];
				jbse_pkg::REG_DIFFERENTIAL: cfg_q.differential <= cfg_data[0];
				jbse_pkg::REG_RESIDUAL:     cfg_q.residual     <= cfg_data[0];
				jbse_pkg::REG_LARGE_RANGE:  cfg_q.large_range  <= cfg_data[0];
				jbse_pkg::REG_PROGRESSIVE:  cfg_q.progressive  <= cfg_data[0];
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	jbse_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.kind        (kind),
		.component   (component),
		.scan_pos    (scan_pos),
		.coefficient (coefficient),
		.cmd_valid   (cmd_valid),
		.cmd         (cmd),
		.cmd_full    (q_full)
	);

	jbse_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (cmd_valid),
		.push_cmd (cmd),
		.full     (q_full),
		.pop      (pop),
		.head     (head),
		.empty    (q_empty)
	);

	jbse_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_empty   (q_empty),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_res   (res)
	);

	assign table_select = res.table_select;
	assign comp_out     = res.comp_out;
	assign symbol       = res.symbol;
	assign run_bits_len = res.run_bits_len;
	assign run_bits     = res.run_bits;
	assign amp_len      = res.amp_len;
	assign amp_bits     = res.amp_bits;
	assign status       = res.status;
	assign last         = res.last;

endmodule

[rtl/jbse_front.sv]
// jbse_front: input stage, point transform, classification and symbol state
// (dc predictors, eob runs, zero run); builds at most one command per item for the queue
// depends on jbse_pkg

module jbse_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  jbse_pkg::cfg_t                       cfg,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 kind,
	input  logic [jbse_pkg::COMP_BITS-1:0]       component,
	input  logic [jbse_pkg::POS_BITS-1:0]        scan_pos,
	input  logic signed [jbse_pkg::COEF_BITS-1:0] coefficient,
	output logic                                 cmd_valid,
	output jbse_pkg::cmd_t                       cmd,
	input  logic                                 cmd_full
);

	typedef enum logic [2:0] {
		SK_NONE,
		SK_DC,
		SK_AC,
		SK_ESC,
		SK_EOB,
		SK_OVF
	} sym_kind_t;

	logic adv;

	// s1 inputs
	logic                                  comp_ok, is_dc, is_ac;
	logic [jbse_pkg::POS_BITS-1:0]         ac_start;
	logic [jbse_pkg::COEF_BITS-1:0]        abs_v, mag_c;
	logic signed [jbse_pkg::COEF_BITS-1:0] dca_c;

	logic                                  s1_valid_q;
	logic                                  flush_s1, dc_s1, at_stop_s1, neg_s1;
	logic [jbse_pkg::COMP_BITS-1:0]        comp_s1;
	logic [jbse_pkg::COEF_BITS-1:0]        mag_s1;
	logic signed [jbse_pkg::COEF_BITS-1:0] dca_s1;

	// symbol state
	logic signed [jbse_pkg::AMP_BITS-1:0]  pred_q [jbse_pkg::COMPONENTS];
	logic [jbse_pkg::EOBR_BITS-1:0]        eobr_q [jbse_pkg::COMPONENTS];
	logic [jbse_pkg::ZRUN_BITS-1:0]        zrun_q;
	logic signed [jbse_pkg::AMP_BITS-1:0]  pred_d [jbse_pkg::COMPONENTS];
	logic [jbse_pkg::EOBR_BITS-1:0]        eobr_d [jbse_pkg::COMPONENTS];
	logic [jbse_pkg::ZRUN_BITS-1:0]        zrun_d, zr_inc;
	logic [jbse_pkg::EOBR_BITS-1:0]        eob_inc;
	logic signed [jbse_pkg::AMP_BITS-1:0]  dca_ext, diff_c;
	logic                                  nz, esc, ovf;

	logic [jbse_pkg::COMPONENTS-1:0]                         mask_c;
	logic [jbse_pkg::COMPONENTS-1:0][jbse_pkg::EOBR_BITS-1:0] runs_c;
	logic [1:0]                                              zrl_c;
	sym_kind_t                                               kind_c;
	logic [jbse_pkg::AMP_BITS-1:0]                           val_c;
	logic                                                    neg_c;
	logic [3:0]                                              run_c;

	logic                                                    s2_valid_q;
	logic [jbse_pkg::COMP_BITS-1:0]                          comp_s2;
	logic [jbse_pkg::COMPONENTS-1:0]                         mask_s2;
	logic [jbse_pkg::COMPONENTS-1:0][jbse_pkg::EOBR_BITS-1:0] runs_s2;
	logic [1:0]                                              zrl_s2;
	sym_kind_t                                               kind_s2;
	logic [jbse_pkg::AMP_BITS-1:0]                           val_s2;
	logic                                                    neg_s2;
	logic [3:0]                                              run_s2;

	// command formatting
	logic [jbse_pkg::AMP_BITS-1:0] mag24, amp;
	logic [jbse_pkg::CAT_BITS-1:0] cat;

	assign adv      = !(s2_valid_q && cmd_full);
	assign in_stall = !adv;

	// classification and point transform
	always_comb begin
		comp_ok  = (3'(component) < 3'(jbse_pkg::COMPONENTS));
		ac_start = (cfg.scan_start != '0) ? cfg.scan_start
			: (cfg.residual ? jbse_pkg::POS_BITS'(0) : jbse_pkg::POS_BITS'(1));
		is_dc    = !kind && comp_ok && (scan_pos == '0) && (cfg.scan_start == '0)
			&& !cfg.residual;
		is_ac    = !kind && comp_ok && !is_dc && (cfg.scan_stop != '0)
			&& (scan_pos >= ac_start) && (scan_pos <= cfg.scan_stop);
		abs_v    = coefficient[jbse_pkg::COEF_BITS-1] ? jbse_pkg::COEF_BITS'(-coefficient)
			: jbse_pkg::COEF_BITS'(coefficient);
		mag_c    = abs_v >> cfg.point_shift;
		dca_c    = coefficient >>> cfg.point_shift;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (adv) begin
			s1_valid_q <= in_valid && (kind || is_dc || is_ac);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			flush_s1   <= kind;
			dc_s1      <= is_dc;
			at_stop_s1 <= (scan_pos == cfg.scan_stop);
			neg_s1     <= coefficient[jbse_pkg::COEF_BITS-1];
			comp_s1    <= component;
			mag_s1     <= mag_c;
			dca_s1     <= dca_c;
		end
	end

	// state update
	always_comb begin
		pred_d  = pred_q;
		eobr_d  = eobr_q;
		zrun_d  = zrun_q;
		mask_c  = '0;
		for (int k = 0; k < jbse_pkg::COMPONENTS; k++) begin
			runs_c[k] = eobr_q[k];
		end
		zrl_c   = '0;
		kind_c  = SK_NONE;
		val_c   = '0;
		neg_c   = 1'b0;
		run_c   = '0;
		dca_ext = jbse_pkg::AMP_BITS'(dca_s1);
		diff_c  = dca_ext - pred_q[comp_s1];
		eob_inc = eobr_q[comp_s1] + 1'b1;
		zr_inc  = (zrun_q == '1) ? zrun_q : zrun_q + 1'b1;
		nz      = (mag_s1 != '0);
		esc     = neg_s1 && (mag_s1 == jbse_pkg::ESC_MAG) && !cfg.progressive && cfg.residual;
		ovf     = nz && !esc && (cfg.large_range
			? ((mag_s1 >> (jbse_pkg::CAT_LIMIT_LR - 1)) != '0)
			: ((mag_s1 >> (jbse_pkg::CAT_LARGE - 1)) != '0));

		if (flush_s1) begin
			if ((cfg.scan_stop != '0) && cfg.progressive) begin
				for (int k = 0; k < jbse_pkg::COMPONENTS; k++) begin
					mask_c[k] = (eobr_q[k] != '0);
				end
			end
			for (int k = 0; k < jbse_pkg::COMPONENTS; k++) begin
				pred_d[k] = '0;
				eobr_d[k] = '0;
			end
			zrun_d = '0;
		end else if (dc_s1) begin
			pred_d[comp_s1] = cfg.differential ? '0 : dca_ext;
			kind_c = SK_DC;
			val_c  = diff_c;
			neg_c  = diff_c[jbse_pkg::AMP_BITS-1];
		end else if (ovf) begin
			kind_c = SK_OVF;
			if (at_stop_s1) begin
				zrun_d = '0;
			end
		end else if (nz) begin
			mask_c[comp_s1] = (eobr_q[comp_s1] != '0);
			eobr_d[comp_s1] = '0;
			zrl_c  = zrun_q[jbse_pkg::ZRUN_BITS-1:4];
			run_c  = zrun_q[3:0];
			kind_c = esc ? SK_ESC : SK_AC;
			val_c  = jbse_pkg::AMP_BITS'(mag_s1);
			neg_c  = neg_s1;
			zrun_d = '0;
		end else if (at_stop_s1) begin
			zrun_d = '0;
			if (cfg.progressive) begin
				if (eob_inc >= jbse_pkg::EOBR_BITS'(jbse_pkg::EOB_RUN_MAX)) begin
					mask_c[comp_s1] = 1'b1;
					runs_c[comp_s1] = eob_inc;
					eobr_d[comp_s1] = '0;
				end else begin
					eobr_d[comp_s1] = eob_inc;
				end
			end else begin
				kind_c = SK_EOB;
			end
		end else begin
			zrun_d = zr_inc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
			zrun_q     <= '0;
			for (int k = 0; k < jbse_pkg::COMPONENTS; k++) begin
				pred_q[k] <= '0;
				eobr_q[k] <= '0;
			end
		end else if (adv) begin
			s2_valid_q <= s1_valid_q && ((mask_c != '0) || (zrl_c != '0) || (kind_c != SK_NONE));
			if (s1_valid_q) begin
				pred_q <= pred_d;
				eobr_q <= eobr_d;
				zrun_q <= zrun_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			comp_s2 <= comp_s1;
			mask_s2 <= mask_c;
			runs_s2 <= runs_c;
			zrl_s2  <= zrl_c;
			kind_s2 <= kind_c;
			val_s2  <= val_c;
			neg_s2  <= neg_c;
			run_s2  <= run_c;
		end
	end

	// category, amplitude bits and the final symbol of the command
	always_comb begin
		mag24 = ((kind_s2 == SK_DC) && neg_s2) ? jbse_pkg::AMP_BITS'(-val_s2) : val_s2;
		cat   = jbse_pkg::bit_length(mag24);
		amp   = (neg_s2 ? ~mag24 : mag24) & jbse_pkg::low_mask(cat);

		cmd.comp          = comp_s2;
		cmd.eob_mask      = mask_s2;
		cmd.eob_runs      = runs_s2;
		cmd.zrl_cnt       = zrl_s2;
		cmd.sym_valid     = (kind_s2 != SK_NONE);
		cmd.sym           = '0;
		cmd.sym.comp_out  = comp_s2;
		cmd.sym.table_select = 1'b1;
		unique case (kind_s2)
			SK_DC: begin
				cmd.sym.table_select = 1'b0;
				cmd.sym.symbol       = 8'(cat);
				cmd.sym.amp_len      = cat;
				cmd.sym.amp_bits     = amp;
			end
			SK_AC: begin
				if (cat >= jbse_pkg::CAT_BITS'(jbse_pkg::CAT_LARGE)) begin
					cmd.sym.symbol       = {4'(cat - jbse_pkg::CAT_BITS'(jbse_pkg::ZRL_SPAN)),
						4'b0};
					cmd.sym.run_bits_len = jbse_pkg::RUN_LEN;
					cmd.sym.run_bits     = run_s2;
				end else begin
					cmd.sym.symbol = {run_s2, cat[3:0]};
				end
				cmd.sym.amp_len  = cat;
				cmd.sym.amp_bits = amp;
			end
			SK_ESC: begin
				cmd.sym.symbol       = jbse_pkg::SYM_ESC;
				cmd.sym.run_bits_len = jbse_pkg::RUN_LEN;
				cmd.sym.run_bits     = run_s2;
			end
			SK_EOB: begin
				cmd.sym.symbol = jbse_pkg::SYM_EOB;
			end
			SK_OVF: begin
				cmd.sym.comp_out = '0;
				cmd.sym.status   = 1'b1;
			end
			default: begin
				cmd.sym.table_select = 1'b1;
			end
		endcase
	end

	assign cmd_valid = s2_valid_q;

endmodule

[rtl/jbse_queue.sv]
// jbse_queue: short command queue between the front and back parts
// depends on jbse_pkg

module jbse_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  jbse_pkg::cmd_t push_cmd,
	output logic           full,
	input  logic           pop,
	output jbse_pkg::cmd_t head,
	output logic           empty
);

	jbse_pkg::cmd_t                  mem_q [jbse_pkg::QUEUE_DEPTH];
	logic [jbse_pkg::QPTR_BITS-1:0]  wr_q, rd_q;
	logic [jbse_pkg::QPTR_BITS:0]    cnt_q;
	logic                            do_push, do_pop;

	assign full    = (cnt_q == (jbse_pkg::QPTR_BITS + 1)'(jbse_pkg::QUEUE_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == jbse_pkg::QPTR_BITS'(jbse_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == jbse_pkg::QPTR_BITS'(jbse_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

endmodule

[rtl/jbse_back.sv]
// jbse_back: expands one command into its result beats (eob runs, zrl, symbol)
// and holds them in the output register; depends on jbse_pkg

module jbse_back (
	input  logic              clk,
	input  logic              arst_n,
	input  jbse_pkg::cmd_t    head,
	input  logic              q_empty,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_stall,
	output jbse_pkg::result_t out_res
);

	jbse_pkg::cmd_t                  cur_q;
	logic                            cur_valid_q;
	logic [jbse_pkg::COMPONENTS-1:0] rem_mask_q, rest_mask;
	logic [1:0]                      zrl_q;
	logic                            out_valid_q;
	jbse_pkg::result_t               out_q, res_c;

	logic                            out_free, fire, done, load;
	logic [jbse_pkg::COMP_BITS-1:0]  k;
	logic [jbse_pkg::EOBR_BITS-1:0]  run;
	logic [jbse_pkg::CAT_BITS-1:0]   s_len;

	always_comb begin
		k = '0;
		for (int i = jbse_pkg::COMPONENTS - 1; i >= 0; i--) begin
			if (rem_mask_q[i]) begin
				k = jbse_pkg::COMP_BITS'(i);
			end
		end
		rest_mask    = rem_mask_q;
		rest_mask[k] = 1'b0;
		run          = cur_q.eob_runs[k];
		s_len        = jbse_pkg::bit_length(jbse_pkg::AMP_BITS'(run)) - 1'b1;
		res_c        = '0;
		if (rem_mask_q != '0) begin
			res_c.table_select = 1'b1;
			res_c.comp_out     = k;
			res_c.symbol       = {s_len[3:0], 4'b0};
			res_c.amp_len      = s_len;
			res_c.amp_bits     = jbse_pkg::AMP_BITS'(run) & jbse_pkg::low_mask(s_len);
			done = (rest_mask == '0) && (zrl_q == '0) && !cur_q.sym_valid;
		end else if (zrl_q != '0) begin
			res_c.table_select = 1'b1;
			res_c.comp_out     = cur_q.comp;
			res_c.symbol       = jbse_pkg::SYM_ZRL;
			done = (zrl_q == 2'd1) && !cur_q.sym_valid;
		end else begin
			res_c = cur_q.sym;
			done  = 1'b1;
		end
		res_c.last = done;
	end

	assign out_free  = !out_valid_q || !out_stall;
	assign fire      = cur_valid_q && out_free;
	assign load      = !cur_valid_q || (fire && done);
	assign pop       = load && !q_empty;
	assign out_valid = out_valid_q;
	assign out_res   = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			cur_valid_q <= 1'b0;
			rem_mask_q  <= '0;
			zrl_q       <= '0;
		end else begin
			if (out_free) begin
				out_valid_q <= fire;
			end
			if (load) begin
				cur_valid_q <= !q_empty;
			end
			if (pop) begin
				rem_mask_q <= head.eob_mask;
				zrl_q      <= head.zrl_cnt;
			end else if (fire) begin
				if (rem_mask_q != '0) begin
					rem_mask_q <= rest_mask;
				end else if (zrl_q != '0) begin
					zrl_q <= zrl_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
		if (fire) begin
			out_q <= res_c;
		end
	end

endmodule

[verif/tb_top.sv]
// tb_top: self-checking bench for jpeg_block_symbol_encoder, predicts every symbol beat
// from its own copy of the scan registers, predictors and run counters; needs jbse_pkg
// and the rtl of the block, nothing else

`timescale 1ns / 100ps

module tb_top;

	localparam int    DRAIN_CYCLES = 40;
	localparam longint CYCLE_LIMIT = 400000;
	localparam longint ESCAPE_VALUE = -32768;

	logic                                   clk = 1'b0;
	logic                                   arst_n = 1'b0;
	logic                                   cfg_we = 1'b0;
	logic [jbse_pkg::IDX_BITS-1:0]          cfg_index = '0;
	logic [jbse_pkg::CFG_BITS-1:0]          cfg_data = '0;
	logic                                   in_valid = 1'b0;
	logic                                   in_stall;
	logic                                   kind = 1'b0;
	logic [jbse_pkg::COMP_BITS-1:0]         component = '0;
	logic [jbse_pkg::POS_BITS-1:0]          scan_pos = '0;
	logic signed [jbse_pkg::COEF_BITS-1:0]  coefficient = '0;
	logic                                   out_valid;
	logic                                   out_stall = 1'b0;
	logic                                   table_select;
	logic [jbse_pkg::COMP_BITS-1:0]         comp_out;
	logic [7:0]                             symbol;
	logic [2:0]                             run_bits_len;
	logic [3:0]                             run_bits;
	logic [jbse_pkg::CAT_BITS-1:0]          amp_len;
	logic [jbse_pkg::AMP_BITS-1:0]          amp_bits;
	logic                                   status;
	logic                                   last;

	jbse_pkg::cfg_t                         scan_cfg;
	logic signed [jbse_pkg::AMP_BITS-1:0]   dc_pred [jbse_pkg::COMPONENTS];
	logic [jbse_pkg::EOBR_BITS-1:0]         eob_count [jbse_pkg::COMPONENTS];
	logic [jbse_pkg::ZRUN_BITS-1:0]         zero_count;
	jbse_pkg::result_t                      pending_symbols [$];
	jbse_pkg::result_t                      want_sym;

	int     send_gap_pct = 0;
	int     recv_stall_pct = 0;
	int     errors = 0;
	int     items_sent = 0;
	int     items_coded = 0;
	int     symbols_checked = 0;
	int     settings_used = 0;
	longint cycle_count = 0;

	jpeg_block_symbol_encoder i_dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("run stopped at the cycle limit with %0d beats outstanding",
				pending_symbols.size());
			$display("tb_top failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	task automatic report(input string what);
		errors++;
		if (errors <= 40) begin
			$display("cycle %0d: %s", cycle_count, what);
		end
	endtask

	task automatic check_field(input string name, input longint unsigned got,
			input longint unsigned want);
		if (got !== want) begin
			report($sformatf("%s is %0h, predicted %0h", name, got, want));
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_symbols.size() == 0) begin
				report($sformatf("unexpected beat, symbol %0h", symbol));
			end else begin
				want_sym = pending_symbols.pop_front();
				symbols_checked++;
				check_field("table_select", table_select, want_sym.table_select);
				check_field("comp_out", comp_out, want_sym.comp_out);
				check_field("symbol", symbol, want_sym.symbol);
				check_field("run_bits_len", run_bits_len, want_sym.run_bits_len);
				check_field("run_bits", run_bits, want_sym.run_bits);
				check_field("amp_len", amp_len, want_sym.amp_len);
				check_field("amp_bits", amp_bits, want_sym.amp_bits);
				check_field("status", status, want_sym.status);
				check_field("last", last, want_sym.last);
			end
		end
	end

	function automatic int unsigned mag_bits(input longint unsigned m);
		int unsigned n;
		n = 0;
		while (m != 0) begin
			n++;
			m = m >> 1;
		end
		return n;
	endfunction

	function automatic longint amp_code(input longint d);
		return (d >= 0) ? d : d - 1;
	endfunction

	function automatic bit is_dc_pos(input int p);
		return p == 0 && scan_cfg.scan_start == 0 && !scan_cfg.residual;
	endfunction

	function automatic bit is_ac_pos(input int p);
		int first;
		first = (scan_cfg.scan_start != 0) ? int'(scan_cfg.scan_start) :
			(scan_cfg.residual ? 0 : 1);
		return scan_cfg.scan_stop != 0 && p >= first && p <= int'(scan_cfg.scan_stop);
	endfunction

	function automatic void emit_symbol(input bit tsel, input int unsigned c,
			input int unsigned sym, input int unsigned rlen, input int unsigned rbits,
			input int unsigned alen, input longint abits, input bit st);
		jbse_pkg::result_t r;
		r.table_select = tsel;
		r.comp_out = jbse_pkg::COMP_BITS'(c);
		r.symbol = 8'(sym);
		r.run_bits_len = 3'(rlen);
		r.run_bits = 4'(rbits);
		r.amp_len = jbse_pkg::CAT_BITS'(alen);
		r.amp_bits = jbse_pkg::AMP_BITS'(abits & ((longint'(1) << alen) - 1));
		r.status = st;
		r.last = 1'b0;
		pending_symbols.push_back(r);
	endfunction

	function automatic void flush_eob_run(input int c);
		int unsigned s;
		if (eob_count[c] != 0) begin
			s = mag_bits(eob_count[c]) - 1;
			emit_symbol(1'b1, c, s << 4, 0, 0, s, eob_count[c], 1'b0);
			eob_count[c] = '0;
		end
	endfunction

	// updates the model state and queues the beats of one input item;
	// returns 0 when the block ignores the item
	function automatic bit encode_item(input logic k,
			input logic [jbse_pkg::COMP_BITS-1:0] c, input logic [jbse_pkg::POS_BITS-1:0] p,
			input logic signed [jbse_pkg::COEF_BITS-1:0] v);
		longint val, q, diff;
		int unsigned cat;
		int n0;
		bit esc, dropped, touched;
		jbse_pkg::result_t r;
		n0 = pending_symbols.size();
		touched = 1'b1;
		dropped = 1'b0;
		val = longint'(v);
		if (k) begin
			if (scan_cfg.scan_stop != 0 && scan_cfg.progressive) begin
				for (int i = 0; i < jbse_pkg::COMPONENTS; i++) flush_eob_run(i);
			end
			for (int i = 0; i < jbse_pkg::COMPONENTS; i++) begin
				dc_pred[i] = '0;
				eob_count[i] = '0;
			end
			zero_count = '0;
		end else if (is_dc_pos(p)) begin
			q = val >>> scan_cfg.point_shift;
			diff = q - longint'(dc_pred[c]);
			dc_pred[c] = scan_cfg.differential ? '0 : jbse_pkg::AMP_BITS'(q);
			cat = mag_bits(diff < 0 ? -diff : diff);
			emit_symbol(1'b0, c, cat, 0, 0, cat, cat != 0 ? amp_code(diff) : 0, 1'b0);
		end else if (is_ac_pos(p)) begin
			q = (val >= 0) ? (val >>> scan_cfg.point_shift) :
				-((-val) >>> scan_cfg.point_shift);
			if (q == 0) begin
				if (zero_count < 63) zero_count++;
			end else begin
				esc = q == ESCAPE_VALUE && !scan_cfg.progressive && scan_cfg.residual;
				cat = mag_bits(q < 0 ? -q : q);
				if (!esc && cat >= (scan_cfg.large_range ? jbse_pkg::CAT_LIMIT_LR
						: jbse_pkg::CAT_LARGE)) begin
					emit_symbol(1'b1, 0, 0, 0, 0, 0, 0, 1'b1);
					if (p == scan_cfg.scan_stop) zero_count = '0;
					dropped = 1'b1;
				end else begin
					flush_eob_run(c);
					while (zero_count > jbse_pkg::ZRL_SPAN) begin
						emit_symbol(1'b1, c, jbse_pkg::SYM_ZRL, 0, 0, 0, 0, 1'b0);
						zero_count = zero_count - jbse_pkg::ZRUN_BITS'(16);
					end
					if (esc)
						emit_symbol(1'b1, c, jbse_pkg::SYM_ESC, jbse_pkg::RUN_LEN,
							zero_count, 0, 0, 1'b0);
					else if (cat >= jbse_pkg::CAT_LARGE)
						emit_symbol(1'b1, c, (cat - jbse_pkg::ZRL_SPAN) << 4,
							jbse_pkg::RUN_LEN, zero_count, cat, amp_code(q), 1'b0);
					else
						emit_symbol(1'b1, c, cat | (zero_count << 4), 0, 0, cat,
							amp_code(q), 1'b0);
					zero_count = '0;
				end
			end
			if (!dropped && p == scan_cfg.scan_stop) begin
				if (zero_count != 0) begin
					if (scan_cfg.progressive) begin
						eob_count[c]++;
						if (int'(eob_count[c]) >= jbse_pkg::EOB_RUN_MAX) flush_eob_run(c);
					end else begin
						emit_symbol(1'b1, c, jbse_pkg::SYM_EOB, 0, 0, 0, 0, 1'b0);
					end
				end
				zero_count = '0;
			end
		end else begin
			touched = 1'b0;
		end
		if (pending_symbols.size() > n0) begin
			r = pending_symbols[pending_symbols.size() - 1];
			r.last = 1'b1;
			pending_symbols[pending_symbols.size() - 1] = r;
		end
		return touched;
	endfunction

	task automatic send_item(input logic k, input logic [jbse_pkg::COMP_BITS-1:0] c,
			input logic [jbse_pkg::POS_BITS-1:0] p,
			input logic signed [jbse_pkg::COEF_BITS-1:0] v);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		component <= c;
		scan_pos <= p;
		coefficient <= v;
		items_sent++;
		if (encode_item(k, c, p, v)) items_coded++;
		do @(posedge clk); while (in_stall);
	endtask

	// wait until every predicted beat is out, then let items without beats drain
	task automatic settle();
		int saved;
		in_valid <= 1'b0;
		while (pending_symbols.size() != 0) @(posedge clk);
		saved = recv_stall_pct;
		recv_stall_pct = 0;
		repeat (DRAIN_CYCLES) @(posedge clk);
		recv_stall_pct = saved;
	endtask

	task automatic write_reg(input jbse_pkg::reg_index_t idx, input int value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= jbse_pkg::CFG_BITS'(value);
		@(posedge clk);
	endtask

	task automatic set_regs(input int start, input int stop, input int shift,
			input bit diff, input bit resid, input bit lr, input bit prog);
		settle();
		write_reg(jbse_pkg::REG_SCAN_START, start);
		write_reg(jbse_pkg::REG_SCAN_STOP, stop);
		write_reg(jbse_pkg::REG_POINT_SHIFT, shift);
		write_reg(jbse_pkg::REG_DIFFERENTIAL, diff);
		write_reg(jbse_pkg::REG_RESIDUAL, resid);
		write_reg(jbse_pkg::REG_LARGE_RANGE, lr);
		write_reg(jbse_pkg::REG_PROGRESSIVE, prog);
		cfg_we <= 1'b0;
		scan_cfg.scan_start = jbse_pkg::POS_BITS'(start);
		scan_cfg.scan_stop = jbse_pkg::POS_BITS'(stop);
		scan_cfg.point_shift = jbse_pkg::SHIFT_BITS'(shift);
		scan_cfg.differential = diff;
		scan_cfg.residual = resid;
		scan_cfg.large_range = lr;
		scan_cfg.progressive = prog;
		settings_used++;
	endtask

	function automatic logic signed [jbse_pkg::COEF_BITS-1:0] random_coef(input int zero_pct);
		int sel;
		int mag;
		logic signed [jbse_pkg::COEF_BITS-1:0] v;
		sel = $urandom_range(99);
		if (sel < zero_pct) return '0;
		sel = $urandom_range(99);
		if (sel < 40) begin
			mag = $urandom_range(15, 1) << scan_cfg.point_shift;
		end else if (sel < 65) begin
			mag = $urandom_range(32767, 1) << scan_cfg.point_shift;
		end else if (sel < 90) begin
			return jbse_pkg::COEF_BITS'($urandom());
		end else begin
			case ($urandom_range(3))
				0: return {1'b0, {(jbse_pkg::COEF_BITS - 1){1'b1}}};
				1: return {1'b1, {(jbse_pkg::COEF_BITS - 1){1'b0}}};
				2: return '1;
				default: mag = 32768 << scan_cfg.point_shift;
			endcase
		end
		v = jbse_pkg::COEF_BITS'(mag);
		return $urandom_range(1) ? -v : v;
	endfunction

	task automatic send_block(input logic [jbse_pkg::COMP_BITS-1:0] c);
		for (int p = 0; p < 64; p++) begin
			if (is_dc_pos(p) || is_ac_pos(p)) begin
				send_item(1'b0, c, jbse_pkg::POS_BITS'(p), random_coef(30 + p));
			end
			if ($urandom_range(99) < 3) begin
				send_item($urandom_range(9) == 0, jbse_pkg::COMP_BITS'($urandom_range(3)),
					jbse_pkg::POS_BITS'($urandom_range(63)), random_coef(30));
			end
		end
		if ($urandom_range(99) < 10) begin
			send_item(1'b1, jbse_pkg::COMP_BITS'($urandom_range(3)),
				jbse_pkg::POS_BITS'($urandom_range(63)), jbse_pkg::COEF_BITS'($urandom()));
		end
	endtask

	task automatic test_sequential_extremes();
		set_regs(0, 63, 0, 0, 0, 0, 0);
		send_item(1'b0, 2'd0, 6'd0, 23'sd4194303);
		send_item(1'b0, 2'd1, 6'd0, -23'sd4194304);
		send_item(1'b0, 2'd0, 6'd0, -23'sd4194304);
		send_item(1'b0, 2'd2, 6'd1, 23'sd0);
		send_item(1'b0, 2'd2, 6'd2, -23'sd32767);
		send_item(1'b0, 2'd2, 6'd3, 23'sd32768);
		send_item(1'b0, 2'd2, 6'd63, 23'sd0);
		send_item(1'b1, 2'd3, 6'd0, 23'sd0);
	endtask

	task automatic test_large_range();
		set_regs(1, 63, 0, 0, 0, 1, 0);
		send_item(1'b0, 2'd1, 6'd1, -23'sd2097151);
		send_item(1'b0, 2'd1, 6'd4, 23'sd0);
		send_item(1'b0, 2'd1, 6'd5, 23'sd2097152);
		send_item(1'b0, 2'd1, 6'd63, -23'sd4194304);
		send_item(1'b0, 2'd1, 6'd63, 23'sd0);
	endtask

	task automatic test_residual_escape();
		set_regs(0, 63, 1, 0, 1, 0, 0);
		send_item(1'b0, 2'd3, 6'd0, -23'sd65536);
		send_item(1'b0, 2'd3, 6'd1, 23'sd0);
		send_item(1'b0, 2'd3, 6'd2, -23'sd65535);
		send_item(1'b0, 2'd3, 6'd63, -23'sd65538);
	endtask

	task automatic test_progressive_runs();
		set_regs(1, 5, 15, 0, 0, 0, 1);
		send_item(1'b0, 2'd1, 6'd5, 23'sd0);
		send_item(1'b0, 2'd1, 6'd5, 23'sd32767);
		send_item(1'b0, 2'd2, 6'd5, -23'sd32767);
		send_item(1'b0, 2'd1, 6'd3, 23'sd4194303);
		send_item(1'b0, 2'd0, 6'd0, -23'sd1);
		send_item(1'b1, 2'd0, 6'd0, 23'sd0);
		send_item(1'b1, 2'd0, 6'd0, 23'sd0);
	endtask

	task automatic test_dc_only_differential();
		set_regs(0, 0, 3, 1, 0, 0, 1);
		send_item(1'b0, 2'd2, 6'd0, -23'sd4194304);
		send_item(1'b0, 2'd2, 6'd0, -23'sd4194304);
		send_item(1'b0, 2'd2, 6'd1, 23'sd5);
		send_item(1'b1, 2'd0, 6'd0, 23'sd0);
	endtask

	task automatic test_start_past_stop();
		set_regs(10, 5, 0, 0, 0, 0, 0);
		send_item(1'b0, 2'd0, 6'd7, 23'sd100);
		send_item(1'b0, 2'd0, 6'd0, 23'sd100);
	endtask

	task automatic test_zero_run_limit();
		set_regs(1, 63, 0, 0, 0, 0, 0);
		repeat (70) send_item(1'b0, 2'd3, 6'd10, 23'sd0);
		send_item(1'b0, 2'd3, 6'd10, -23'sd1);
		send_item(1'b0, 2'd3, 6'd63, 23'sd0);
	endtask

	task automatic test_random_scans();
		int start, stop, shift, sel, tmp, target;
		bit resid;
		for (int s = 0; s < 9; s++) begin
			if (s < 3) begin
				send_gap_pct = 15;
				recv_stall_pct = 60;
			end else if (s < 6) begin
				send_gap_pct = 60;
				recv_stall_pct = 15;
			end else begin
				send_gap_pct = 0;
				recv_stall_pct = 0;
			end
			sel = $urandom_range(9);
			start = (sel < 4) ? 0 : (sel < 6) ? 1 : $urandom_range(63);
			sel = $urandom_range(9);
			stop = (sel < 5) ? 63 : (sel == 5) ? 0 : $urandom_range(63);
			sel = $urandom_range(9);
			shift = (sel < 5) ? 0 : (sel == 5) ? 15 : $urandom_range(15);
			resid = 1'($urandom_range(1));
			if (start > stop) begin
				tmp = start;
				start = stop;
				stop = tmp;
			end
			if (stop == 0) begin
				start = 0;
				resid = 1'b0;
			end
			if (s == 0) begin
				start = 0;
				stop = 63;
			end
			set_regs(start, stop, shift, 1'($urandom_range(1)), resid,
				1'($urandom_range(1)), 1'($urandom_range(1)));
			target = items_coded + 20;
			while (items_coded < target) send_block(jbse_pkg::COMP_BITS'($urandom_range(3)));
		end
	endtask

	initial begin
		for (int i = 0; i < jbse_pkg::COMPONENTS; i++) begin
			dc_pred[i] = '0;
			eob_count[i] = '0;
		end
		zero_count = '0;
		scan_cfg = '0;
		scan_cfg.scan_stop = 6'd63;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_gap_pct = 15;
		recv_stall_pct = 60;
		test_sequential_extremes();
		test_large_range();
		test_residual_escape();
		test_progressive_runs();
		test_dc_only_differential();
		test_start_past_stop();
		test_zero_run_limit();
		test_random_scans();
		settle();
		$display("%0d items sent (%0d coded), %0d symbol beats checked", items_sent,
			items_coded, symbols_checked);
		$display("%0d register settings, %0d mismatches", settings_used, errors);
		if (errors == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

endmodule
